// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the voxel cylinder painter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VCP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define VCP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VCP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define VCP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/vcp_pkg.sv -----
// Package for the voxel cylinder painter: register indexes, pipeline constants
// and the pipeline control struct. No dependencies.
package vcp_pkg;

    localparam int PIPE_STAGES = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X     = 3'd0,
        CFG_START_Y     = 3'd1,
        CFG_START_Z     = 3'd2,
        CFG_END_X       = 3'd3,
        CFG_END_Y       = 3'd4,
        CFG_END_Z       = 3'd5,
        CFG_TUBE_RADIUS = 3'd6,
        CFG_PAINT_VALUE = 3'd7
    } t_cfg_idx;

    // per-stage load enables and valid bits
    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;
        logic [PIPE_STAGES-1:0] vld;
    } t_pipe;

endpackage

// ----- rtl/vcp_wide_mul.sv -----
// Two-stage unsigned multiplier: four half-width partial products, then a sum.
// No package dependencies; used for the squares and the radius term.
module vcp_wide_mul #(
    parameter int AW = 49,
    parameter int BW = 49
) (
    input  logic          i_clk,
    input  logic          i_en_pp,
    input  logic          i_en_sum,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic [AW+BW-1:0] o_p
);
    localparam int LA = (AW + 1) / 2;
    localparam int HA = AW - LA;
    localparam int LB = (BW + 1) / 2;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic [LA+LB-1:0] r_ll;
    logic [LA+HB-1:0] r_lh;
    logic [HA+LB-1:0] r_hl;
    logic [HA+HB-1:0] r_hh;
    logic [PW-1:0]    r_p;
    logic [PW-1:0]    n_p;

    always_ff @(posedge i_clk) begin
        if (i_en_pp) begin
            r_ll <= i_a[LA-1:0]  * i_b[LB-1:0];
            r_lh <= i_a[LA-1:0]  * i_b[BW-1:LB];
            r_hl <= i_a[AW-1:LA] * i_b[LB-1:0];
            r_hh <= i_a[AW-1:LA] * i_b[BW-1:LB];
        end
    end

    always_comb begin
        n_p = (PW'(r_hh) << (LA + LB)) + (PW'(r_hl) << LA)
            + (PW'(r_lh) << LB) + PW'(r_ll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/vcp_pipe_ctrl.sv -----
// Valid bits and bubble-collapsing load enables for the painter pipeline.
// Depends on vcp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vcp_pipe_ctrl import vcp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_stall,
    output logic  o_in_stall,
    output t_pipe o_pipe
);
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic [PIPE_STAGES-1:0] en;
    logic                   in_acc;
    logic                   out_acc;

    // a stage loads when empty or when the stage after it moves
    always_comb begin
        en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || !i_out_stall;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign in_acc     = i_in_valid && en[0];
    assign out_acc    = r_vld[PIPE_STAGES-1] && !i_out_stall;
    assign o_in_stall = !en[0];
    assign o_pipe.en  = en;
    assign o_pipe.vld = r_vld;

    `VCP_ASSERT_NXT(a_item_count, i_clk, i_rst_n, i_rst_n,
        $countones(r_vld) == $countones($past(r_vld)) + 32'($past(in_acc))
            - 32'($past(out_acc)), "pipeline lost or repeated an item")
    `VCP_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_in_stall, &r_vld,
        "input stalled while a bubble is in the pipeline")

endmodule

// ----- rtl/vcp_front.sv -----
// Stages 1-4 of the painter: offsets, products, dot/cross sums, range test.
// Also derives axis length squared and radius squared from the registers.
// Depends on vcp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vcp_front import vcp_pkg::*; #(
    parameter int CW  = 24,
    parameter int PXW = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pipe               i_pipe,
    input  logic signed [CW-1:0] i_start_x,
    input  logic signed [CW-1:0] i_start_y,
    input  logic signed [CW-1:0] i_start_z,
    input  logic signed [CW-1:0] i_end_x,
    input  logic signed [CW-1:0] i_end_y,
    input  logic signed [CW-1:0] i_end_z,
    input  logic [CW-2:0]       i_radius,
    input  logic signed [CW-1:0] i_point_x,
    input  logic signed [CW-1:0] i_point_y,
    input  logic signed [CW-1:0] i_point_z,
    input  logic signed [PXW-1:0] i_pixel,
    output logic [2*CW+1:0]     o_l2,
    output logic [2*CW-3:0]     o_r2,
    output logic                o_ok,
    output logic [2*CW:0]       o_ax,
    output logic [2*CW:0]       o_ay,
    output logic [2*CW:0]       o_az,
    output logic signed [PXW-1:0] o_pixel
);
    localparam int DW   = CW + 1;      // offset width
    localparam int PW   = 2 * DW;      // product width
    localparam int DOTW = PW + 1;
    localparam int L2W  = 2 * CW + 2;
    localparam int AXW  = PW - 1;
    localparam int RW   = CW - 1;
    localparam int R2W  = 2 * RW;

    // configuration side, free running
    logic signed [DW-1:0]  r_dx, r_dy, r_dz;
    logic [RW-1:0]         r_rad;
    logic signed [PW-1:0]  r_ddx, r_ddy, r_ddz;
    logic [R2W-1:0]        r_r2a, r_r2b;
    logic [L2W-1:0]        r_l2;

    always_ff @(posedge i_clk) begin
        r_dx  <= DW'(i_end_x) - DW'(i_start_x);
        r_dy  <= DW'(i_end_y) - DW'(i_start_y);
        r_dz  <= DW'(i_end_z) - DW'(i_start_z);
        r_rad <= i_radius;
        r_ddx <= r_dx * r_dx;
        r_ddy <= r_dy * r_dy;
        r_ddz <= r_dz * r_dz;
        r_r2a <= r_rad * r_rad;
        r_l2  <= L2W'(r_ddx) + L2W'(r_ddy) + L2W'(r_ddz);
        r_r2b <= r_r2a;
    end

    // stage 1: offsets from the segment start
    logic signed [DW-1:0]  r1_px, r1_py, r1_pz;
    logic signed [PXW-1:0] r1_pix;

    always_ff @(posedge i_clk) begin
        if (i_pipe.en[0]) begin
            r1_px  <= DW'(i_point_x) - DW'(i_start_x);
            r1_py  <= DW'(i_point_y) - DW'(i_start_y);
            r1_pz  <= DW'(i_point_z) - DW'(i_start_z);
            r1_pix <= i_pixel;
        end
    end

    // stage 2: dot terms and cross terms
    logic signed [PW-1:0]  r2_mx, r2_my, r2_mz;
    logic signed [PW-1:0]  r2_yz, r2_zy, r2_zx, r2_xz, r2_xy, r2_yx;
    logic signed [PXW-1:0] r2_pix;

    always_ff @(posedge i_clk) begin
        if (i_pipe.en[1]) begin
            r2_mx  <= r1_px * r_dx;
            r2_my  <= r1_py * r_dy;
            r2_mz  <= r1_pz * r_dz;
            r2_yz  <= r1_py * r_dz;
            r2_zy  <= r1_pz * r_dy;
            r2_zx  <= r1_pz * r_dx;
            r2_xz  <= r1_px * r_dz;
            r2_xy  <= r1_px * r_dy;
            r2_yx  <= r1_py * r_dx;
            r2_pix <= r1_pix;
        end
    end

    // stage 3: p.d and p x d
    logic signed [DOTW-1:0] r3_dot;
    logic signed [PW-1:0]   r3_cx, r3_cy, r3_cz;
    logic signed [PXW-1:0]  r3_pix;

    always_ff @(posedge i_clk) begin
        if (i_pipe.en[2]) begin
            r3_dot <= {r2_mx[PW-1], r2_mx} + {r2_my[PW-1], r2_my}
                    + {r2_mz[PW-1], r2_mz};
            r3_cx  <= r2_yz - r2_zy;
            r3_cy  <= r2_zx - r2_xz;
            r3_cz  <= r2_xy - r2_yx;
            r3_pix <= r2_pix;
        end
    end

    // stage 4: 0 <= dot <= L2 with L2 > 0, cross magnitudes
    logic                  n4_ok;
    logic signed [PW-1:0]  n4_tx, n4_ty, n4_tz;
    logic                  r4_ok;
    logic [AXW-1:0]        r4_ax, r4_ay, r4_az;
    logic signed [PXW-1:0] r4_pix;

    always_comb begin
        n4_ok = (r_l2 != '0) && !r3_dot[DOTW-1] && (r3_dot[DOTW-2:0] <= r_l2);
        n4_tx = r3_cx[PW-1] ? -r3_cx : r3_cx;
        n4_ty = r3_cy[PW-1] ? -r3_cy : r3_cy;
        n4_tz = r3_cz[PW-1] ? -r3_cz : r3_cz;
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe.en[3]) begin
            r4_ok  <= n4_ok;
            r4_ax  <= n4_tx[AXW-1:0];
            r4_ay  <= n4_ty[AXW-1:0];
            r4_az  <= n4_tz[AXW-1:0];
            r4_pix <= r3_pix;
        end
    end

    assign o_l2    = r_l2;
    assign o_r2    = r_r2b;
    assign o_ok    = r4_ok;
    assign o_ax    = r4_ax;
    assign o_ay    = r4_ay;
    assign o_az    = r4_az;
    assign o_pixel = r4_pix;

    `VCP_ASSERT_NXT(a_zero_len_out, i_clk, i_rst_n,
        i_pipe.en[3] && (r_l2 == '0), !r4_ok,
        "zero-length axis passed the projection test")

endmodule

// ----- rtl/voxel_cylinder_painter_unit.sv -----
// Voxel cylinder painter, top level. Depends on vcp_pkg, vcp_pipe_ctrl,
// vcp_front, vcp_wide_mul and assert_macros.svh.
//
// Streams voxels, one per unstalled clock, and repaints those that fall in a
// capped cylinder around the segment start..end with radius tube_radius (signed
// fixed point, same scale as the point; the radius is unsigned). A voxel is
// inside when the axis has nonzero length, its projection dot =
// (p-start).(end-start) lies in 0..L2 (L2 = |end-start|^2, both ends inclusive)
// and |(p-start) x d|^2 <= r^2 * L2, which is the exact, division-free distance
// test. Inside voxels leave with paint_value and inside_res = 1, others with
// their own pixel. Throughput is one voxel per cycle while the output is not
// stalled. There are 8 register stages; the result is held in the stage 8
// output register until it leaves. The depth is set by the 25x25 product
// stage and the 49x49 squares, which are split into four half-width partial
// products plus a registered sum. Stalls collapse bubbles, so the input
// keeps taking voxels while a result waits, until every stage is full.
// Configuration writes are always ready; write only while no voxel is
// in flight.
`include "assert_macros.svh"
module voxel_cylinder_painter_unit import vcp_pkg::*; #(
    parameter int COORD_WIDTH = 24,
    parameter int PIXEL_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    input  logic signed [PIXEL_WIDTH-1:0] i_pixel_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [PIXEL_WIDTH-1:0] o_pixel_out,
    output logic                        o_inside_res
);
    localparam int AXW   = 2 * COORD_WIDTH + 1;  // cross product magnitude
    localparam int SQW   = 2 * AXW;
    localparam int SUMW  = SQW + 2;
    localparam int L2W   = 2 * COORD_WIDTH + 2;
    localparam int R2W   = 2 * (COORD_WIDTH - 1);
    localparam int R2L2W = R2W + L2W;

    // ---------------- configuration registers ----------------
    logic signed [COORD_WIDTH-1:0] r_start_x, r_start_y, r_start_z;
    logic signed [COORD_WIDTH-1:0] r_end_x, r_end_y, r_end_z;
    logic [COORD_WIDTH-2:0]        r_radius;
    logic signed [PIXEL_WIDTH-1:0] r_paint;

    assign o_cfg_ready = 1'b1;

    // bits above each register's width are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_z <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
            r_end_z   <= '0;
            r_radius  <= '0;
            r_paint   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_X:     r_start_x <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_START_Y:     r_start_y <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_START_Z:     r_start_z <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_END_X:       r_end_x   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_END_Y:       r_end_y   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_END_Z:       r_end_z   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_TUBE_RADIUS: r_radius  <= i_cfg_data[COORD_WIDTH-2:0];
                CFG_PAINT_VALUE: r_paint   <= i_cfg_data[PIXEL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    t_pipe pipe;

    vcp_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_pipe      (pipe)
    );

    // ---------------- stages 1-4 ----------------
    logic [L2W-1:0]         l2;
    logic [R2W-1:0]         r2;
    logic                   ok4;
    logic [AXW-1:0]         ax4, ay4, az4;
    logic signed [PIXEL_WIDTH-1:0] pix4;

    vcp_front #(
        .CW  (COORD_WIDTH),
        .PXW (PIXEL_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pipe    (pipe),
        .i_start_x (r_start_x),
        .i_start_y (r_start_y),
        .i_start_z (r_start_z),
        .i_end_x   (r_end_x),
        .i_end_y   (r_end_y),
        .i_end_z   (r_end_z),
        .i_radius  (r_radius),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_pixel   (i_pixel_in),
        .o_l2      (l2),
        .o_r2      (r2),
        .o_ok      (ok4),
        .o_ax      (ax4),
        .o_ay      (ay4),
        .o_az      (az4),
        .o_pixel   (pix4)
    );

    // r^2 * L2 depends on configuration only; free running, ready by stage 5
    logic [R2L2W-1:0] r2l2;

    vcp_wide_mul #(
        .AW (R2W),
        .BW (L2W)
    ) u_mul_rl (
        .i_clk    (i_clk),
        .i_en_pp  (1'b1),
        .i_en_sum (1'b1),
        .i_a      (r2),
        .i_b      (l2),
        .o_p      (r2l2)
    );

    // ---------------- stages 5-6: squared cross components ----------------
    logic [SQW-1:0] sqx, sqy, sqz;

    vcp_wide_mul #(.AW(AXW), .BW(AXW)) u_sq_x (
        .i_clk (i_clk), .i_en_pp (pipe.en[4]), .i_en_sum (pipe.en[5]),
        .i_a (ax4), .i_b (ax4), .o_p (sqx)
    );
    vcp_wide_mul #(.AW(AXW), .BW(AXW)) u_sq_y (
        .i_clk (i_clk), .i_en_pp (pipe.en[4]), .i_en_sum (pipe.en[5]),
        .i_a (ay4), .i_b (ay4), .o_p (sqy)
    );
    vcp_wide_mul #(.AW(AXW), .BW(AXW)) u_sq_z (
        .i_clk (i_clk), .i_en_pp (pipe.en[4]), .i_en_sum (pipe.en[5]),
        .i_a (az4), .i_b (az4), .o_p (sqz)
    );

    logic                          r5_ok, r6_ok;
    logic signed [PIXEL_WIDTH-1:0] r5_pix, r6_pix;

    always_ff @(posedge i_clk) begin
        if (pipe.en[4]) begin
            r5_ok  <= ok4;
            r5_pix <= pix4;
        end
        if (pipe.en[5]) begin
            r6_ok  <= r5_ok;
            r6_pix <= r5_pix;
        end
    end

    // ---------------- stage 7: |p x d|^2 ----------------
    logic [SUMW-1:0]               r7_sum;
    logic                          r7_ok;
    logic signed [PIXEL_WIDTH-1:0] r7_pix;

    always_ff @(posedge i_clk) begin
        if (pipe.en[6]) begin
            r7_sum <= SUMW'(sqx) + SUMW'(sqy) + SUMW'(sqz);
            r7_ok  <= r6_ok;
            r7_pix <= r6_pix;
        end
    end

    // ---------------- stage 8: radius test, output register ----------------
    logic                          n_inside;
    logic                          r_inside;
    logic signed [PIXEL_WIDTH-1:0] r_pix_out;

    assign n_inside = r7_ok && (r7_sum <= SUMW'(r2l2));

    always_ff @(posedge i_clk) begin
        if (pipe.en[7]) begin
            r_inside  <= n_inside;
            r_pix_out <= n_inside ? r_paint : r7_pix;
        end
    end

    assign o_out_valid  = pipe.vld[PIPE_STAGES-1];
    assign o_pixel_out  = r_pix_out;
    assign o_inside_res = r_inside;

    `VCP_ASSERT_NXT(a_range_gate, i_clk, i_rst_n,
        pipe.en[7] && pipe.vld[6] && !r7_ok, !o_inside_res,
        "voxel outside the axis range was painted")

endmodule
